>>> hw/rtl/bblur_pkg.sv
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types, constants and helpers of the 3x3 box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W    = 32;                         // pixel word
	localparam int RGB_W    = 24;                         // stored red/green/blue
	localparam int CH_W     = 8;
	localparam int DIM_W    = 11;                         // config register width
	localparam int COL_W    = $clog2(MAX_WIDTH);          // line store address
	localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);     // rows up to height+1
	localparam int CNT_W    = $clog2(MAX_WIDTH + 2);      // priming count up to width+1
	localparam int SUM_W    = 12;                         // nine bytes summed
	localparam int PROD_W   = 25;
	localparam int CFG_IDX_W = 2;

	// floor(x/9) == (x * 7282) >> 16 for every x below 2296
	localparam int RECIP9   = 7282;
	localparam int RECIP_SH = 16;

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [RGB_W-1:0]     rgb_t;
	typedef logic [CH_W-1:0]      ch_t;
	typedef logic [DIM_W-1:0]     dim_t;
	typedef logic [COL_W-1:0]     col_t;
	typedef logic [ROW_W-1:0]     row_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [SUM_W-1:0]     sum_t;
	typedef logic [PROD_W-1:0]    prod_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_FRAME_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_FRAME_HEIGHT = cfg_idx_t'(1);

	localparam dim_t WIDTH_RESET  = dim_t'(640);
	localparam dim_t HEIGHT_RESET = dim_t'(480);
	localparam ch_t  ALPHA_OPAQUE = ch_t'(8'hFF);

	// register value as used: zero reads as one, above the maximum saturates
	function automatic dim_t clamp_dim(input dim_t v, input dim_t hi);
		dim_t r;
		if (v == dim_t'(0))
			r = dim_t'(1);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

	function automatic ch_t div9(input sum_t s);
		prod_t p;
		p = prod_t'(s) * prod_t'(RECIP9);
		return p[RECIP_SH +: CH_W];
	endfunction

endpackage

>>> hw/rtl/bblur_if.sv
// ----------------------------------------------------------------------------
// bblur_if
// Valid/ready channels of the 3x3 box blur: pixel in, pixel out, config.
// ----------------------------------------------------------------------------
interface bblur_in_if;
	logic                 valid;
	logic                 ready;
	bblur_pkg::pix_t      pixel_word;
	logic                 padding;

	modport source (output valid, pixel_word, padding, input ready);
	modport sink   (input valid, pixel_word, padding, output ready);
endinterface

interface bblur_out_if;
	logic                 valid;
	logic                 ready;
	bblur_pkg::pix_t      blurred_pixel;
	logic                 last_of_frame;

	modport source (output valid, blurred_pixel, last_of_frame, input ready);
	modport sink   (input valid, blurred_pixel, last_of_frame, output ready);
endinterface

interface bblur_cfg_if;
	logic                 valid;
	logic                 ready;
	bblur_pkg::cfg_idx_t  index;
	bblur_pkg::dim_t      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/box_blur_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box average of a raster-order RGBA8888 stream, zero outside the frame.
// ----------------------------------------------------------------------------
// Usage:
//   pixels  - input transactions, one pixel of the frame each, raster order.
//             After the W*H frame pixels the feeder sends W+1 padded items
//             to flush the last row. Taken one per clock unless stalled.
//   blurred - output transactions; the first one of a frame follows input
//             item W+2, then one per input item. last_of_frame marks the
//             final one, after which a new frame starts.
//   cfg     - register writes (0: frame_width, 1: frame_height), always
//             ready. Any write to a known register restarts the frame. Write
//             only while no transaction is in flight.
// Path: each result passes s1, s2 and the output register in turn.
// Throughput: one pixel per clock unless stalled, set by the single read and
//   single write port of each 1024x24 line store (read at accept, write back).
// Reset: counters, window and pipeline valids clear; width 640, height 480.
//   Line stores are not cleared; entries are used only after being written.
// Stall: the output register holds while blurred.ready is low; the pipeline
//   keeps filling until its two stages are full, then pixels.ready drops.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb (
	input  logic         clk,
	input  logic         arst_n,
	bblur_in_if.sink     pixels,
	bblur_out_if.source  blurred,
	bblur_cfg_if.sink    cfg
);

	// ------------------------------------------------------------------
	// configuration
	// ------------------------------------------------------------------
	bblur_pkg::dim_t width_q, height_q;
	bblur_pkg::dim_t w_eff, h_eff;
	logic            cfg_wr, cfg_restart;

	assign cfg.ready   = 1'b1;
	assign cfg_wr      = cfg.valid && cfg.ready;
	assign cfg_restart = cfg_wr && (cfg.index == bblur_pkg::REG_FRAME_WIDTH ||
		cfg.index == bblur_pkg::REG_FRAME_HEIGHT);

	assign w_eff = bblur_pkg::clamp_dim(width_q, bblur_pkg::dim_t'(bblur_pkg::MAX_WIDTH));
	assign h_eff = bblur_pkg::clamp_dim(height_q, bblur_pkg::dim_t'(bblur_pkg::MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bblur_pkg::WIDTH_RESET;
			height_q <= bblur_pkg::HEIGHT_RESET;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				bblur_pkg::REG_FRAME_WIDTH:  width_q  <= cfg.data;
				bblur_pkg::REG_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline handshake: s1 (store read data), s2 (channel sums), output
	// ------------------------------------------------------------------
	logic valid_s1, valid_s2, out_valid_q;
	logic emit_s1;
	logic out_free, s2_free, s2_adv, s1_adv, s1_free, accept;

	assign out_free = !out_valid_q || blurred.ready;
	assign s2_adv   = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || out_free;
	// items that give no result drop out at s1
	assign s1_adv   = valid_s1 && (!emit_s1 || s2_free);
	assign s1_free  = !valid_s1 || s1_adv;

	assign pixels.ready = s1_free;
	assign accept       = pixels.valid && pixels.ready;

	// ------------------------------------------------------------------
	// input position, evaluated at accept
	// ------------------------------------------------------------------
	bblur_pkg::col_t col_q;
	bblur_pkg::row_t row_q;
	bblur_pkg::cnt_t primed_q;
	bblur_pkg::dim_t col_inc;
	bblur_pkg::row_t h_row;
	bblur_pkg::cnt_t w_cnt1;
	logic            in_pix_ok, in_top_ok, in_mid_ok, in_emit, in_last, in_col0;
	bblur_pkg::rgb_t in_pix;

	assign h_row     = bblur_pkg::row_t'(h_eff);
	assign w_cnt1    = bblur_pkg::cnt_t'(w_eff) + bblur_pkg::cnt_t'(1);
	assign col_inc   = bblur_pkg::dim_t'(col_q) + bblur_pkg::dim_t'(1);
	assign in_col0   = (col_q == '0);
	assign in_pix_ok = !pixels.padding && (row_q < h_row);
	assign in_pix    = in_pix_ok ? pixels.pixel_word[bblur_pkg::PIX_W-1 -: bblur_pkg::RGB_W]
		: '0;
	assign in_top_ok = (row_q >= bblur_pkg::row_t'(2)) &&
		((row_q - bblur_pkg::row_t'(2)) < h_row);
	assign in_mid_ok = (row_q >= bblur_pkg::row_t'(1)) &&
		((row_q - bblur_pkg::row_t'(1)) < h_row);
	assign in_emit   = (primed_q >= w_cnt1);
	assign in_last   = (row_q == h_row + bblur_pkg::row_t'(1)) && in_col0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			primed_q <= '0;
		end else if (cfg_restart) begin
			col_q    <= '0;
			row_q    <= '0;
			primed_q <= '0;
		end else if (accept) begin
			if (in_last) begin
				col_q    <= '0;
				row_q    <= '0;
				primed_q <= '0;
			end else begin
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= row_q + bblur_pkg::row_t'(1);
				end else begin
					col_q <= bblur_pkg::col_t'(col_inc);
				end
				if (!in_emit)
					primed_q <= primed_q + bblur_pkg::cnt_t'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// line stores: read at accept, written back when s1 advances
	// ------------------------------------------------------------------
	bblur_pkg::rgb_t older_mem [bblur_pkg::MAX_WIDTH];
	bblur_pkg::rgb_t newer_mem [bblur_pkg::MAX_WIDTH];
	bblur_pkg::rgb_t rd_older_s1, rd_newer_s1;
	bblur_pkg::rgb_t older_fwd_q, newer_fwd_q;
	bblur_pkg::rgb_t older_val, newer_val;
	bblur_pkg::col_t addr_s1;
	bblur_pkg::rgb_t pix_s1;
	logic            fwd_s1, col0_s1, top_ok_s1, mid_ok_s1, last_s1;

	// the entry the next item reads may be the one s1 writes on the same
	// edge (width one, or a frame boundary); the store then returns stale data
	assign older_val = fwd_s1 ? older_fwd_q : rd_older_s1;
	assign newer_val = fwd_s1 ? newer_fwd_q : rd_newer_s1;

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			older_mem[addr_s1] <= newer_val;
			newer_mem[addr_s1] <= pix_s1;
		end
		if (accept) begin
			rd_older_s1 <= older_mem[col_q];
			rd_newer_s1 <= newer_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			older_fwd_q <= newer_val;
			newer_fwd_q <= pix_s1;
			addr_s1     <= col_q;
			pix_s1      <= in_pix;
			col0_s1     <= in_col0;
			top_ok_s1   <= in_top_ok;
			mid_ok_s1   <= in_mid_ok;
			emit_s1     <= in_emit;
			last_s1     <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= s1_adv && (addr_s1 == col_q);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// s1: 3x3 window and channel sums
	// window index is column*3 + row; column 2 newest, row 2 lowest
	// ------------------------------------------------------------------
	bblur_pkg::rgb_t win_q [9];
	bblur_pkg::rgb_t new_col [3];
	bblur_pkg::sum_t sum_r, sum_g, sum_b;

	assign new_col[0] = top_ok_s1 ? older_val : '0;
	assign new_col[1] = mid_ok_s1 ? newer_val : '0;
	assign new_col[2] = pix_s1;

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int i = 3; i < 9; i++) begin
			sum_r = sum_r + bblur_pkg::sum_t'(win_q[i][23:16]);
			sum_g = sum_g + bblur_pkg::sum_t'(win_q[i][15:8]);
			sum_b = sum_b + bblur_pkg::sum_t'(win_q[i][7:0]);
		end
		// start of a row closes the previous row's right edge with zeros
		if (!col0_s1) begin
			for (int k = 0; k < 3; k++) begin
				sum_r = sum_r + bblur_pkg::sum_t'(new_col[k][23:16]);
				sum_g = sum_g + bblur_pkg::sum_t'(new_col[k][15:8]);
				sum_b = sum_b + bblur_pkg::sum_t'(new_col[k][7:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (cfg_restart) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (s1_adv) begin
			if (last_s1) begin
				for (int i = 0; i < 9; i++)
					win_q[i] <= '0;
			end else if (col0_s1) begin
				for (int i = 0; i < 6; i++)
					win_q[i] <= '0;
				for (int k = 0; k < 3; k++)
					win_q[6 + k] <= new_col[k];
			end else begin
				for (int i = 0; i < 6; i++)
					win_q[i] <= win_q[i + 3];
				for (int k = 0; k < 3; k++)
					win_q[6 + k] <= new_col[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// s2: sums held for the divide by nine
	// ------------------------------------------------------------------
	bblur_pkg::sum_t sum_r_s2, sum_g_s2, sum_b_s2;
	logic            last_s2;

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			sum_r_s2 <= sum_r;
			sum_g_s2 <= sum_g;
			sum_b_s2 <= sum_b;
			last_s2  <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s1_adv && emit_s1)
			valid_s2 <= 1'b1;
		else if (s2_adv)
			valid_s2 <= 1'b0;
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	bblur_pkg::pix_t blurred_q;
	logic            last_q;

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			blurred_q <= {bblur_pkg::div9(sum_r_s2), bblur_pkg::div9(sum_g_s2),
				bblur_pkg::div9(sum_b_s2), bblur_pkg::ALPHA_OPAQUE};
			last_q    <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s2_adv)
			out_valid_q <= 1'b1;
		else if (blurred.ready)
			out_valid_q <= 1'b0;
	end

	assign blurred.valid         = out_valid_q;
	assign blurred.blurred_pixel = blurred_q;
	assign blurred.last_of_frame = last_q;

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 RGB box blur. Whole frames, cut frames and
// stray items go in through the pixel channel with random gaps on both sides.
// A predictor in the bench keeps its own line stores, window and position,
// and every blurred transaction is checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 8;
	// pause after the drain for an item still in flight that gives no result
	localparam int SETTLE_CYCLES = 6;
	// longest quiet stretch in a good run is one random gap plus the settle
	// pause; this leaves a wide margin
	localparam int STALL_LIMIT   = 2000;
	localparam int RANDOM_ITEMS  = 430;
	// final stretch of the random part runs with no gaps at all
	localparam int CALM_ITEMS    = 150;
	// items sent into frames too large to finish within the run
	localparam int CUT_ITEMS     = 40;
	localparam int TALL_ITEMS    = 60;

	// indexes the block has no register for; writes must be ignored
	localparam bblur_pkg::cfg_idx_t REG_SPARE_A = bblur_pkg::cfg_idx_t'(2);
	localparam bblur_pkg::cfg_idx_t REG_SPARE_B = bblur_pkg::cfg_idx_t'(3);

	typedef struct packed {
		bblur_pkg::pix_t pixel;
		logic            ends_frame;
	} blur_t;

	logic clk;
	logic arst_n;

	bblur_in_if  pix_if ();
	bblur_out_if out_if ();
	bblur_cfg_if cfg_if ();

	box_blur_3x3_rgb dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_if),
		.blurred (out_if),
		.cfg     (cfg_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: a private copy of everything the block keeps.
	// ------------------------------------------------------------------
	bblur_pkg::rgb_t row_two_up [bblur_pkg::MAX_WIDTH];   // row two above the input row
	bblur_pkg::rgb_t row_one_up [bblur_pkg::MAX_WIDTH];   // row just above the input row
	bblur_pkg::rgb_t win [9];                             // col*3 + row, col 2 newest
	int unsigned     col_at;
	int unsigned     row_at;
	int unsigned     primed_items;
	bblur_pkg::dim_t width_set;
	bblur_pkg::dim_t height_set;

	blur_t           pending_blurs [$];

	// pacing knobs, flipped per phase
	bit              source_gaps;
	bit              sink_gaps;

	int unsigned     fails;
	int unsigned     pixels_sent;
	int unsigned     blurs_checked;
	int unsigned     frames_seen;
	int unsigned     reg_writes;
	int unsigned     random_items;

	// zero reads as one, anything above the maximum as the maximum
	function automatic int unsigned dim_in_use(input bblur_pkg::dim_t v,
	                                           input int unsigned hi);
		if (v == '0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic bblur_pkg::pix_t window_average();
		int unsigned red;
		int unsigned grn;
		int unsigned blu;
		red = 0;
		grn = 0;
		blu = 0;
		for (int k = 0; k < 9; k++) begin
			red += win[k][23:16];
			grn += win[k][15:8];
			blu += win[k][7:0];
		end
		return {bblur_pkg::ch_t'(red / 9), bblur_pkg::ch_t'(grn / 9),
			bblur_pkg::ch_t'(blu / 9), bblur_pkg::ALPHA_OPAQUE};
	endfunction

	task automatic shift_column(input bblur_pkg::rgb_t top, input bblur_pkg::rgb_t mid,
	                            input bblur_pkg::rgb_t bot);
		for (int k = 0; k < 6; k++)
			win[k] = win[k + 3];
		win[6] = top;
		win[7] = mid;
		win[8] = bot;
	endtask

	// position, priming count and window go back to the frame start;
	// the line stores keep what they hold
	task automatic restart_frame_state();
		col_at       = 0;
		row_at       = 0;
		primed_items = 0;
		for (int k = 0; k < 9; k++)
			win[k] = '0;
	endtask

	// One accepted pixel transaction: advance the private state and queue
	// the blurred pixel it releases, if any.
	task automatic blur_one_pixel(input bblur_pkg::pix_t word, input logic pad);
		int unsigned     w;
		int unsigned     h;
		int unsigned     c;
		int unsigned     r;
		bblur_pkg::rgb_t pix;
		bblur_pkg::rgb_t top;
		bblur_pkg::rgb_t mid;
		bblur_pkg::pix_t avg;
		logic            emit;
		logic            ends_frame;
		blur_t           item;

		w   = dim_in_use(width_set, bblur_pkg::MAX_WIDTH);
		h   = dim_in_use(height_set, bblur_pkg::MAX_HEIGHT);
		c   = (col_at >= w) ? 0 : col_at;
		r   = row_at;
		// padding and anything past the last frame row count as black
		pix = (pad || r >= h) ? '0 : word[31:8];
		top = (r >= 2 && r - 2 < h) ? row_two_up[c] : '0;
		mid = (r >= 1 && r - 1 < h) ? row_one_up[c] : '0;

		if (c == 0) begin
			// close the previous row's right edge with a zero column,
			// then the window restarts with just this column
			shift_column('0, '0, '0);
			avg = window_average();
			for (int k = 0; k < 6; k++)
				win[k] = '0;
			win[6] = top;
			win[7] = mid;
			win[8] = pix;
		end else begin
			shift_column(top, mid, pix);
			avg = window_average();
		end

		emit       = (primed_items >= w + 1);
		ends_frame = (r == h + 1) && (c == 0);

		row_two_up[c] = row_one_up[c];
		row_one_up[c] = pix;

		if (ends_frame) begin
			restart_frame_state();
		end else begin
			c++;
			if (c >= w) begin
				c = 0;
				r++;
			end
			col_at = c;
			row_at = r;
			if (primed_items < w + 1)
				primed_items++;
		end

		if (emit) begin
			item.pixel      = avg;
			item.ends_frame = ends_frame;
			pending_blurs.push_back(item);
		end
	endtask

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	function automatic bblur_pkg::pix_t pick_word();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// One pixel transaction. Ready is looked at on the falling edge, where
	// both sides are settled; the transaction then completes at the next
	// rising edge. Valid stays high on return so back-to-back items flow.
	task automatic send_pixel(input bblur_pkg::pix_t word, input logic pad);
		bit taken;
		if (source_gaps && $urandom_range(0, 7) == 0) begin
			pix_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		pix_if.valid      <= 1'b1;
		pix_if.pixel_word <= word;
		pix_if.padding    <= pad;
		do begin
			@(negedge clk);
			taken = pix_if.ready;
			@(posedge clk);
		end while (!taken);
		blur_one_pixel(word, pad);
		pixels_sent++;
	endtask

	// n items of a w x h frame: frame pixels first (now and then padded),
	// then the flush zone (mostly padding, now and then a stray pixel)
	task automatic send_frame(input int unsigned w, input int unsigned h,
	                          input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if (i < w * h)
				send_pixel(pick_word(), $urandom_range(0, 15) == 0);
			else
				send_pixel(pick_word(), $urandom_range(0, 7) != 0);
		end
	endtask

	// Block goes idle: input stops, every expected result drains out, and the
	// SETTLE_CYCLES pause passes for an item still in flight that releases nothing.
	task automatic settle();
		pix_if.valid <= 1'b0;
		while (pending_blurs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// more = 1 keeps valid up for a write that follows right away
	task automatic write_reg(input bblur_pkg::cfg_idx_t idx, input bblur_pkg::dim_t value,
	                         input bit more);
		bit taken;
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do begin
			@(negedge clk);
			taken = cfg_if.ready;
			@(posedge clk);
		end while (!taken);
		case (idx)
			bblur_pkg::REG_FRAME_WIDTH: begin
				width_set = value;
				restart_frame_state();
			end
			bblur_pkg::REG_FRAME_HEIGHT: begin
				height_set = value;
				restart_frame_state();
			end
			default: ;
		endcase
		reg_writes++;
		if (!more)
			cfg_if.valid <= 1'b0;
	endtask

	task automatic set_size(input bblur_pkg::dim_t w, input bblur_pkg::dim_t h);
		settle();
		write_reg(bblur_pkg::REG_FRAME_WIDTH, w, 1'b1);
		write_reg(bblur_pkg::REG_FRAME_HEIGHT, h, 1'b0);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset size is 640 x 480: priming takes 641 items, so a short burst
	// must release nothing. The frame is cut short; the next test rewrites
	// the size.
	task automatic test_reset_size();
		send_frame(640, 480, CUT_ITEMS);
	endtask

	task automatic test_directed_frames();
		// 3x3 all white: centre hits the largest sum, edges darken
		set_size(bblur_pkg::dim_t'(3), bblur_pkg::dim_t'(3));
		repeat (9) send_pixel('1, 1'b0);
		repeat (4) send_pixel('0, 1'b1);

		// same size, back to back: bit patterns, a padded pixel inside the
		// frame and a non-padding item in the flush zone
		send_pixel(32'hFF00FF00, 1'b0);
		send_pixel(32'h00FF00FF, 1'b0);
		send_pixel(32'hAAAAAAAA, 1'b0);
		send_pixel(32'h55555555, 1'b0);
		send_pixel(32'hDEADBEEF, 1'b1);
		send_pixel(32'hFFFFFFFF, 1'b0);
		send_pixel(32'h00000000, 1'b0);
		send_pixel(32'h80808080, 1'b0);
		send_pixel(32'h7F7F7F7F, 1'b0);
		send_pixel(32'hFFFFFFFF, 1'b0);
		repeat (3) send_pixel($urandom, 1'b1);

		// zero in both registers reads as a 1x1 frame
		set_size('0, '0);
		send_pixel('1, 1'b0);
		send_pixel('1, 1'b0);
		send_pixel('1, 1'b1);

		// writes to unused indexes change nothing: still 1x1
		settle();
		write_reg(REG_SPARE_A, '1, 1'b1);
		write_reg(REG_SPARE_B, bblur_pkg::dim_t'(11'h2AA), 1'b0);
		send_pixel(32'h12345678, 1'b0);
		send_pixel(32'h9ABCDEF0, 1'b1);
		send_pixel(32'hFFFFFFFF, 1'b0);
	endtask

	// Largest sizes, one at the limit and one clamped from all ones. The
	// wide frames are cut before priming ends, so nothing may come out;
	// the tall ones give a result per item from the third on.
	task automatic test_size_extremes();
		set_size(bblur_pkg::dim_t'(bblur_pkg::MAX_WIDTH), bblur_pkg::dim_t'(1));
		send_frame(bblur_pkg::MAX_WIDTH, 1, CUT_ITEMS);
		set_size('1, bblur_pkg::dim_t'(1));
		send_frame(bblur_pkg::MAX_WIDTH, 1, CUT_ITEMS);
		set_size(bblur_pkg::dim_t'(1), bblur_pkg::dim_t'(bblur_pkg::MAX_HEIGHT));
		send_frame(1, bblur_pkg::MAX_HEIGHT, TALL_ITEMS);
		set_size(bblur_pkg::dim_t'(1), '1);
		send_frame(1, bblur_pkg::MAX_HEIGHT, TALL_ITEMS);
	endtask

	// Mostly whole frames of small random size, frames of the same size
	// back to back, and now and then a frame cut short by a size write.
	task automatic test_random_frames();
		int unsigned     w;
		int unsigned     h;
		int unsigned     full;
		int unsigned     n;
		bblur_pkg::dim_t raw_w;
		bblur_pkg::dim_t raw_h;
		bit              resize;
		bit              cut;

		w      = 1;
		h      = 1;
		resize = 1'b1;
		while (random_items < RANDOM_ITEMS) begin
			if (random_items + CALM_ITEMS >= RANDOM_ITEMS) begin
				source_gaps = 1'b0;
				sink_gaps   = 1'b0;
			end else begin
				source_gaps = ($urandom_range(0, 3) != 0);
				sink_gaps   = ($urandom_range(0, 3) != 0);
			end

			if (resize || $urandom_range(0, 2) == 0) begin
				if ($urandom_range(0, 7) == 0) begin
					w = $urandom_range(7, 40);
					h = $urandom_range(1, 3);
				end else begin
					w = $urandom_range(1, 6);
					h = $urandom_range(1, 5);
				end
				raw_w = (w == 1 && $urandom_range(0, 1)) ? bblur_pkg::dim_t'(0)
					: bblur_pkg::dim_t'(w);
				raw_h = (h == 1 && $urandom_range(0, 1)) ? bblur_pkg::dim_t'(0)
					: bblur_pkg::dim_t'(h);
				set_size(raw_w, raw_h);
			end

			full = w * h + w + 1;
			cut  = ($urandom_range(0, 7) == 0);
			n    = cut ? $urandom_range(1, full - 1) : full;
			send_frame(w, h, n);
			random_items += n;
			// a cut frame leaves the block mid-frame: rewrite to restart
			resize = cut;
		end
	endtask

	// ------------------------------------------------------------------
	// Result checker: the handshake is read on the falling edge and the
	// transaction completes at the following rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin : check_blur
		blur_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (pending_blurs.size() == 0) begin
				$error("blurred transaction with nothing expected: %h",
				       out_if.blurred_pixel);
				fails++;
			end else begin
				want = pending_blurs.pop_front();
				if (out_if.blurred_pixel !== want.pixel) begin
					$error("blurred_pixel: expected %h, got %h",
					       want.pixel, out_if.blurred_pixel);
					fails++;
				end
				if (out_if.last_of_frame !== want.ends_frame) begin
					$error("last_of_frame: expected %0b, got %0b",
					       want.ends_frame, out_if.last_of_frame);
					fails++;
				end
				if (want.ends_frame)
					frames_seen++;
				blurs_checked++;
			end
		end
	end

	// Output side pacing: random stall bursts while sink_gaps is set.
	initial begin : sink_pacing
		int unsigned hold;
		hold         = 0;
		out_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold != 0)
				hold--;
			else if (sink_gaps && $urandom_range(0, 9) == 0)
				hold = $urandom_range(1, 12);
			out_if.ready <= (hold == 0);
		end
	end

	// Watchdog: too long without any transaction on any channel ends the run.
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((pix_if.valid && pix_if.ready) || (out_if.valid && out_if.ready) ||
			    (cfg_if.valid && cfg_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("timeout: no transaction for %0d cycles, %0d results outstanding",
		         STALL_LIMIT, pending_blurs.size());
		$display("tb_top NOT OK");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		clk               = 1'b0;
		arst_n            = 1'b0;
		pix_if.valid      = 1'b0;
		pix_if.pixel_word = '0;
		pix_if.padding    = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = bblur_pkg::REG_FRAME_WIDTH;
		cfg_if.data       = '0;
		source_gaps       = 1'b1;
		sink_gaps         = 1'b1;
		fails             = 0;
		pixels_sent       = 0;
		blurs_checked     = 0;
		frames_seen       = 0;
		reg_writes        = 0;
		random_items      = 0;

		// predictor starts at the reset size; store contents never matter
		width_set  = bblur_pkg::WIDTH_RESET;
		height_set = bblur_pkg::HEIGHT_RESET;
		for (int k = 0; k < bblur_pkg::MAX_WIDTH; k++) begin
			row_two_up[k] = '0;
			row_one_up[k] = '0;
		end
		restart_frame_state();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_directed_frames();
		test_size_extremes();
		test_random_frames();

		// drain, then a short tail to catch any extra output
		settle();

		$display("covered %0d pixel transactions and %0d register writes,",
		         pixels_sent, reg_writes);
		$display("%0d blurred pixels checked over %0d complete frames, plus clamped sizes",
		         blurs_checked, frames_seen);
		if (fails == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/bblur_pkg.sv
hw/rtl/bblur_if.sv
hw/rtl/box_blur_3x3_rgb.sv
sim/tb_top.sv
